// ===== rtl/core/rhpc_pkg.sv =====
// Shared constants for the RGB/HSV pixel converter.
// No dependencies; used by the word interface and the converter top level.
package rhpc_pkg;

  localparam int FIELD_W        = 16;
  localparam int COMPONENT_BITS = 16;

  localparam logic [2:0] SEC_RED_RISE_GREEN = 3'd0;
  localparam logic [2:0] SEC_GREEN_FALL_RED = 3'd1;
  localparam logic [2:0] SEC_GREEN_RISE_BLU = 3'd2;
  localparam logic [2:0] SEC_BLUE_FALL_GRN  = 3'd3;
  localparam logic [2:0] SEC_BLUE_RISE_RED  = 3'd4;

  localparam logic DIR_RGB_TO_HSV = 1'b0;
  localparam logic DIR_HSV_TO_RGB = 1'b1;

endpackage

// ===== rtl/core/rhpc_pix_if.sv =====
// Valid/ready channel that carries one pixel word of four components.
// Depends on rhpc_pkg for the default component width.
interface rhpc_pix_if #(
  parameter int W = rhpc_pkg::FIELD_W
);
  logic         valid;
  logic         ready;
  logic [W-1:0] first;
  logic [W-1:0] second;
  logic [W-1:0] third;
  logic [W-1:0] alpha;

  modport source (output valid, output first, output second, output third, output alpha,
                  input ready);
  modport sink   (input valid, input first, input second, input third, input alpha,
                  output ready);
endinterface

// ===== rtl/core/rgb_hsv_pixel_converter_unit.sv =====
// RGB/HSV pixel converter top level: pipelined datapath and output skid stage.
// Depends on rhpc_pkg and rhpc_pix_if.
//
// Usage:
//   pix_in  carries one pixel word (first, second, third, alpha) per handshake;
//           pix_out returns one converted word for every accepted word, in order.
//   cfg_we/cfg_wdata write the direction bit: 0 turns RGB into HSV, 1 turns
//   HSV into RGB. Write it only while no word is in flight.
//   Components are COMPONENT_BITS-bit fractions with all ones meaning 1.0;
//   hue is a fraction of a full turn. Alpha passes through unchanged.
// Timing:
//   One word per cycle while pix_out takes every word. The pipeline depth is
//   set by the two restoring dividers for
//   saturation and hue that retire one quotient bit per stage.
// Reset (rst, synchronous): clears the direction bit to RGB to HSV and
//   empties the pipeline and the skid register.
// Stall: when pix_out is not taken, the word at the pipeline end moves into
//   the skid register and the pipeline then holds until the skid drains.
module rgb_hsv_pixel_converter_unit #(
  parameter int COMPONENT_BITS = rhpc_pkg::COMPONENT_BITS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  logic  cfg_wdata,
  rhpc_pix_if.sink   pix_in,
  rhpc_pix_if.source pix_out
);

  localparam int B = COMPONENT_BITS;
  localparam int L = B + 3;
  localparam logic [B-1:0]     CMAX  = '1;
  localparam logic [2*B-1:0]   RND_C = (2*B)'(CMAX >> 1);
  localparam logic [2*B+1:0]   RND_T = (2*B+2)'(1) << (B-1);

  typedef struct packed {
    logic           valid;
    logic           dir;
    logic           zero;
    logic [2:0]     sector;
    logic [B-1:0]   alpha;
    logic [B-1:0]   c0;
    logic [B-1:0]   c1;
    logic [B-1:0]   c2;
    logic [B-1:0]   va;
    logic [B-1:0]   den_s;
    logic [B-1:0]   lo_s;
    logic [B-1:0]   q_s;
    logic [B-1:0]   rem_s;
    logic [B+2:0]   den_h;
    logic [B+2:0]   rem_h;
    logic [B-1:0]   q_h;
    logic [2*B-1:0] x1;
    logic [2*B-1:0] x2;
    logic [2*B-1:0] x3;
    logic [B:0]     e1;
    logic [B:0]     e2;
    logic [B:0]     e3;
  } stage_t;

  logic         direction;
  logic         en;
  stage_t       st  [L];
  stage_t       nxt [L];
  logic         sk_valid;
  logic [B-1:0] sk_c0;
  logic [B-1:0] sk_c1;
  logic [B-1:0] sk_c2;
  logic [B-1:0] sk_alpha;

  function automatic logic [B:0] div_cmax_est(input logic [2*B-1:0] y);
    logic [2*B:0] s;
    s = (2*B+1)'(y) + (2*B+1)'(y >> B) + (2*B+1)'(1);
    return s[2*B:B];
  endfunction

  function automatic logic [B:0] div_cmax_fix(input logic [2*B-1:0] y, input logic [B:0] e);
    logic signed [2*B+2:0] r;
    r = $signed({3'b000, y}) - $signed(((2*B+3)'(e) << B) - (2*B+3)'(e));
    if (r < 0) begin
      return e - (B+1)'(1);
    end else if (r >= $signed((2*B+3)'(CMAX))) begin
      return e + (B+1)'(1);
    end
    return e;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= rhpc_pkg::DIR_RGB_TO_HSV;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
    end
  end

  assign en           = !sk_valid;
  assign pix_in.ready = en;

  always_comb begin
    nxt[0]       = '0;
    nxt[0].valid = pix_in.valid;
    nxt[0].dir   = direction;
    nxt[0].c0    = pix_in.first;
    nxt[0].c1    = pix_in.second;
    nxt[0].c2    = pix_in.third;
    nxt[0].alpha = pix_in.alpha;
  end

  for (genvar k = 1; k < L; k++) begin : g_stage
    always_comb begin
      stage_t                p;
      stage_t                n_st;
      logic [B-1:0]          mx;
      logic [B-1:0]          mn;
      logic [B-1:0]          d;
      logic signed [B+3:0]   hn;
      logic signed [B+3:0]   d6;
      logic [2*B-1:0]        ns;
      logic [B+2:0]          h6;
      logic [B:0]            ts;
      logic [B+3:0]          th;
      logic                  ge_s;
      logic                  ge_h;
      logic [B:0]            tf;
      logic [2*B+1:0]        pa;
      logic [2*B+1:0]        pb;
      logic [2*B:0]          yy1;
      logic [2*B:0]          yy2;
      logic [2*B:0]          yy3;
      logic                  up_s;
      logic                  up_h;
      p    = st[k-1];
      n_st = p;
      mx   = p.c0;
      mn   = p.c0;
      d    = '0;
      hn   = '0;
      d6   = '0;
      ns   = '0;
      h6   = '0;
      ts   = '0;
      th   = '0;
      ge_s = 1'b0;
      ge_h = 1'b0;
      tf   = '0;
      pa   = '0;
      pb   = '0;
      yy1  = '0;
      yy2  = '0;
      yy3  = '0;
      up_s = 1'b0;
      up_h = 1'b0;
      if (k == 1) begin
        if (p.c1 > mx) mx = p.c1;
        if (p.c2 > mx) mx = p.c2;
        if (p.c1 < mn) mn = p.c1;
        if (p.c2 < mn) mn = p.c2;
        d  = mx - mn;
        d6 = ($signed({4'b0000, d}) <<< 2) + ($signed({4'b0000, d}) <<< 1);
        if (p.c0 == mx) begin
          hn = $signed({4'b0000, p.c1}) - $signed({4'b0000, p.c2});
        end else if (p.c1 == mx) begin
          hn = ($signed({4'b0000, d}) <<< 1) + $signed({4'b0000, p.c2})
             - $signed({4'b0000, p.c0});
        end else begin
          hn = ($signed({4'b0000, d}) <<< 2) + $signed({4'b0000, p.c0})
             - $signed({4'b0000, p.c1});
        end
        if (hn < 0) hn = hn + d6;
        ns = ((2*B)'(d) << B) - (2*B)'(d);
        h6 = ((B+3)'(p.c0) << 2) + ((B+3)'(p.c0) << 1);
        if (p.dir == rhpc_pkg::DIR_RGB_TO_HSV) begin
          n_st.va    = mx;
          n_st.zero  = (d == '0);
          n_st.den_s = mx;
          n_st.rem_s = ns[2*B-1:B];
          n_st.lo_s  = ns[B-1:0];
          n_st.den_h = d6[B+2:0];
          n_st.rem_h = hn[B+2:0];
          n_st.q_s   = '0;
          n_st.q_h   = '0;
        end else begin
          n_st.va     = p.c2;
          n_st.zero   = (p.c1 == '0);
          n_st.sector = h6[B+2:B];
          n_st.x1     = (2*B)'(h6[B-1:0]);
        end
      end
      if (k >= 2 && k <= B + 1) begin
        ts   = {p.rem_s, p.lo_s[B-1]};
        ge_s = (ts >= {1'b0, p.den_s});
        n_st.rem_s = ge_s ? B'(ts - {1'b0, p.den_s}) : ts[B-1:0];
        n_st.q_s   = {p.q_s[B-2:0], ge_s};
        n_st.lo_s  = p.lo_s << 1;
        th   = {p.rem_h, 1'b0};
        ge_h = (th >= {1'b0, p.den_h});
        n_st.rem_h = ge_h ? (B+3)'(th - {1'b0, p.den_h}) : th[B+2:0];
        n_st.q_h   = {p.q_h[B-2:0], ge_h};
      end
      if (k == 2) begin
        tf = {1'b1, {B{1'b0}}} - {1'b0, p.x1[B-1:0]};
        pa = (2*B+2)'(p.c1) * (2*B+2)'(p.x1[B-1:0]) + RND_T;
        pb = (2*B+2)'(p.c1) * (2*B+2)'(tf) + RND_T;
        n_st.x2 = (2*B)'(pa[2*B-1:B]);
        n_st.x3 = (2*B)'(pb[2*B-1:B]);
      end
      if (k == 3) begin
        n_st.x1 = (2*B)'(p.va) * (2*B)'(CMAX - p.c1);
        n_st.x2 = (2*B)'(p.va) * (2*B)'(CMAX - p.x2[B-1:0]);
        n_st.x3 = (2*B)'(p.va) * (2*B)'(CMAX - p.x3[B-1:0]);
      end
      if (k == 4) begin
        yy1 = (2*B+1)'(p.x1) + (2*B+1)'(RND_C);
        yy2 = (2*B+1)'(p.x2) + (2*B+1)'(RND_C);
        yy3 = (2*B+1)'(p.x3) + (2*B+1)'(RND_C);
        n_st.x1 = yy1[2*B-1:0];
        n_st.x2 = yy2[2*B-1:0];
        n_st.x3 = yy3[2*B-1:0];
        n_st.e1 = div_cmax_est(yy1[2*B-1:0]);
        n_st.e2 = div_cmax_est(yy2[2*B-1:0]);
        n_st.e3 = div_cmax_est(yy3[2*B-1:0]);
      end
      if (k == 5) begin
        n_st.e1 = div_cmax_fix(p.x1, p.e1);
        n_st.e2 = div_cmax_fix(p.x2, p.e2);
        n_st.e3 = div_cmax_fix(p.x3, p.e3);
      end
      if (k == 6 && p.dir == rhpc_pkg::DIR_HSV_TO_RGB) begin
        if (p.zero) begin
          n_st.c0 = p.va;
          n_st.c1 = p.va;
          n_st.c2 = p.va;
        end else begin
          case (p.sector)
            rhpc_pkg::SEC_RED_RISE_GREEN: begin
              n_st.c0 = p.va;            n_st.c1 = p.e3[B-1:0]; n_st.c2 = p.e1[B-1:0];
            end
            rhpc_pkg::SEC_GREEN_FALL_RED: begin
              n_st.c0 = p.e2[B-1:0];     n_st.c1 = p.va;        n_st.c2 = p.e1[B-1:0];
            end
            rhpc_pkg::SEC_GREEN_RISE_BLU: begin
              n_st.c0 = p.e1[B-1:0];     n_st.c1 = p.va;        n_st.c2 = p.e3[B-1:0];
            end
            rhpc_pkg::SEC_BLUE_FALL_GRN: begin
              n_st.c0 = p.e1[B-1:0];     n_st.c1 = p.e2[B-1:0]; n_st.c2 = p.va;
            end
            rhpc_pkg::SEC_BLUE_RISE_RED: begin
              n_st.c0 = p.e3[B-1:0];     n_st.c1 = p.e1[B-1:0]; n_st.c2 = p.va;
            end
            default: begin
              n_st.c0 = p.va;            n_st.c1 = p.e1[B-1:0]; n_st.c2 = p.e2[B-1:0];
            end
          endcase
        end
      end
      if (k == L - 1 && p.dir == rhpc_pkg::DIR_RGB_TO_HSV) begin
        up_s = ({p.rem_s, 1'b0} >= {1'b0, p.den_s});
        up_h = ({p.rem_h, 1'b0} >= {1'b0, p.den_h});
        n_st.c2 = p.va;
        if (p.zero) begin
          n_st.c0 = '0;
          n_st.c1 = '0;
        end else begin
          n_st.c0 = p.q_h + B'(up_h);
          n_st.c1 = p.q_s + B'(up_s);
        end
      end
      nxt[k] = n_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < L; i++) begin
        st[i].valid <= 1'b0;
      end
    end else if (en) begin
      st <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_valid <= 1'b0;
    end else if (sk_valid) begin
      if (pix_out.ready) sk_valid <= 1'b0;
    end else if (st[L-1].valid && !pix_out.ready) begin
      sk_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!sk_valid && st[L-1].valid && !pix_out.ready) begin
      sk_c0    <= st[L-1].c0;
      sk_c1    <= st[L-1].c1;
      sk_c2    <= st[L-1].c2;
      sk_alpha <= st[L-1].alpha;
    end
  end

  assign pix_out.valid  = sk_valid || st[L-1].valid;
  assign pix_out.first  = sk_valid ? sk_c0    : st[L-1].c0;
  assign pix_out.second = sk_valid ? sk_c1    : st[L-1].c1;
  assign pix_out.third  = sk_valid ? sk_c2    : st[L-1].c2;
  assign pix_out.alpha  = sk_valid ? sk_alpha : st[L-1].alpha;

endmodule

// ===== tb/tb_rgb_hsv_pixel_converter_unit.sv =====
// Testbench for the RGB/HSV pixel converter: directed and random pixels in both
// directions, bursty source, stalling sink, scoreboard with its own conversion.
// Depends on rhpc_pkg, rhpc_pix_if and rgb_hsv_pixel_converter_unit.
`timescale 1ns / 1ps

module tb_rgb_hsv_pixel_converter_unit;

  localparam int B = 16;
  localparam longint unsigned CMAX = (64'd1 << B) - 1;
  localparam longint unsigned TURN = 64'd1 << B;
  localparam int LATENCY = B + 3;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [B-1:0] first;
    logic [B-1:0] second;
    logic [B-1:0] third;
    logic [B-1:0] alpha;
  } pixel_t;

  function automatic longint unsigned rdiv(longint unsigned num, longint unsigned den);
    return (num + den / 2) / den;
  endfunction

  function automatic pixel_t convert_pixel(logic dir, pixel_t px);
    longint unsigned r, g, b, mx, mn, d, h, s, v, h6, f, sf, sf1, p, q, t;
    longint n;
    pixel_t o;
    o.alpha = px.alpha;
    if (dir == rhpc_pkg::DIR_RGB_TO_HSV) begin
      r = 64'(px.first); g = 64'(px.second); b = 64'(px.third);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d = mx - mn;
      o.third = mx[B-1:0];
      if (d == 0) begin
        o.first = '0;
        o.second = '0;
      end else begin
        o.second = B'(rdiv(d * CMAX, mx));
        if (r == mx) n = longint'(g) - longint'(b);
        else if (g == mx) n = longint'(2 * d) + longint'(b) - longint'(r);
        else n = longint'(4 * d) + longint'(r) - longint'(g);
        if (n < 0) n += longint'(6 * d);
        o.first = B'(rdiv(longint'(n) * TURN, 6 * d) & CMAX);
      end
    end else begin
      h = 64'(px.first); s = 64'(px.second); v = 64'(px.third);
      if (s == 0) begin
        o.first = B'(v); o.second = B'(v); o.third = B'(v);
      end else begin
        h6 = h * 6;
        f = h6 & CMAX;
        sf = (s * f + TURN / 2) >> B;
        sf1 = (s * (TURN - f) + TURN / 2) >> B;
        p = rdiv(v * (CMAX - s), CMAX);
        q = rdiv(v * (CMAX - sf), CMAX);
        t = rdiv(v * (CMAX - sf1), CMAX);
        case (3'(h6 >> B))
          rhpc_pkg::SEC_RED_RISE_GREEN: begin
            o.first = B'(v); o.second = B'(t); o.third = B'(p);
          end
          rhpc_pkg::SEC_GREEN_FALL_RED: begin
            o.first = B'(q); o.second = B'(v); o.third = B'(p);
          end
          rhpc_pkg::SEC_GREEN_RISE_BLU: begin
            o.first = B'(p); o.second = B'(v); o.third = B'(t);
          end
          rhpc_pkg::SEC_BLUE_FALL_GRN: begin
            o.first = B'(p); o.second = B'(q); o.third = B'(v);
          end
          rhpc_pkg::SEC_BLUE_RISE_RED: begin
            o.first = B'(t); o.second = B'(p); o.third = B'(v);
          end
          default: begin
            o.first = B'(v); o.second = B'(p); o.third = B'(q);
          end
        endcase
      end
    end
    return o;
  endfunction

  class pixel_scoreboard;
    pixel_t pending[$];
    int errors;
    logic dir;

    function void note_input(pixel_t px);
      pending.push_back(convert_pixel(dir, px));
    endfunction

    function void check_output(pixel_t got);
      pixel_t exp;
      if (pending.size() == 0) begin
        $error("unexpected word %h", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.first !== exp.first) begin
        $error("first: expected %0d, got %0d", exp.first, got.first); errors++;
      end
      if (got.second !== exp.second) begin
        $error("second: expected %0d, got %0d", exp.second, got.second); errors++;
      end
      if (got.third !== exp.third) begin
        $error("third: expected %0d, got %0d", exp.third, got.third); errors++;
      end
      if (got.alpha !== exp.alpha) begin
        $error("alpha: expected %0d, got %0d", exp.alpha, got.alpha); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_wdata = 0;
  bit long_stall = 0;
  bit stall_mode = 0;
  int idle_cycles = 0;
  pixel_scoreboard sb;

  rhpc_pix_if #(.W(B)) pix_in ();
  rhpc_pix_if #(.W(B)) pix_out ();

  rgb_hsv_pixel_converter_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .pix_in(pix_in), .pix_out(pix_out)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  initial begin
    pix_in.valid = 0;
    pix_in.first = 0; pix_in.second = 0; pix_in.third = 0; pix_in.alpha = 0;
    pix_out.ready = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (pix_in.valid && pix_in.ready)
        sb.note_input({pix_in.first, pix_in.second, pix_in.third, pix_in.alpha});
      if (pix_out.valid && pix_out.ready)
        sb.check_output({pix_out.first, pix_out.second, pix_out.third, pix_out.alpha});
      if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL rgb_hsv_pixel_converter_unit");
        $finish;
      end
    end
  end

  // receiver stall pattern: alternate free-running and random stalls, held off in reset or a long stall
  always @(negedge clk) begin
    if (rst || long_stall)
      pix_out.ready <= 0;
    else if (stall_mode)
      pix_out.ready <= ($urandom_range(0, 3) != 0);
    else
      pix_out.ready <= 1;
  end

  initial begin
    forever begin
      repeat ($urandom_range(20, 120)) @(negedge clk);
      stall_mode = ~stall_mode;
    end
  end

  int burst_left = 0;

  task automatic send_pixel(pixel_t px);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        pix_in.valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    pix_in.valid <= 1;
    pix_in.first <= px.first; pix_in.second <= px.second;
    pix_in.third <= px.third; pix_in.alpha <= px.alpha;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid once a sequence of words is done
  task automatic end_burst();
    pix_in.valid <= 0;
    burst_left = 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_direction(logic dir);
    drain();
    cfg_we <= 1;
    cfg_wdata <= dir;
    @(negedge clk);
    cfg_we <= 0;
    sb.dir = dir;
  endtask

  function automatic logic [B-1:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CMAX[B-1:0];
      2: return B'($urandom_range(0, 15));
      3: return B'(CMAX - $urandom_range(0, 15));
      default: return B'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.first = rand_comp();
    px.second = rand_comp();
    px.third = rand_comp();
    px.alpha = B'($urandom);
    if ($urandom_range(0, 7) == 0) px.second = px.first;
    if ($urandom_range(0, 7) == 0) px.third = px.first;
    return px;
  endfunction

  task automatic directed_rgb();
    send_pixel({16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'h8000, 16'h8000, 16'h8000, 16'h1234});
    send_pixel({16'hFFFF, 16'h0000, 16'h0000, 16'hA5A5});
    send_pixel({16'hFFFF, 16'h0000, 16'h0001, 16'h5A5A});
    send_pixel({16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001});
    send_pixel({16'h0000, 16'hFFFF, 16'h0000, 16'h8000});
    send_pixel({16'h0000, 16'h0000, 16'hFFFF, 16'h7FFF});
    send_pixel({16'hFFFF, 16'h0000, 16'hFFFF, 16'h0F0F});
    send_pixel({16'h0001, 16'h0000, 16'h0000, 16'hF0F0});
    send_pixel({16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000});
    end_burst();
  endtask

  task automatic directed_hsv();
    send_pixel({16'h1234, 16'h0000, 16'h8000, 16'h0001});
    send_pixel({16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF});
    send_pixel({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000});
    send_pixel({16'h2AAB, 16'hFFFF, 16'hFFFF, 16'h1111});
    send_pixel({16'h5555, 16'h8000, 16'hFFFF, 16'h2222});
    send_pixel({16'h8000, 16'hFFFF, 16'h8000, 16'h3333});
    send_pixel({16'hAAAB, 16'h0001, 16'hFFFF, 16'h4444});
    send_pixel({16'hD555, 16'hFFFF, 16'h0000, 16'h5555});
    send_pixel({16'hFFFF, 16'h0001, 16'h0001, 16'h6666});
    send_pixel({16'h2AAA, 16'hFFFF, 16'h0001, 16'h7777});
    end_burst();
  endtask

  initial begin
    sb = new();
    sb.dir = rhpc_pkg::DIR_RGB_TO_HSV;
    repeat (5) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    directed_rgb();
    set_direction(rhpc_pkg::DIR_HSV_TO_RGB);
    directed_hsv();
    // hold the sink off while the source keeps offering words
    fork
      begin
        long_stall = 1;
        repeat (200) @(negedge clk);
        long_stall = 0;
      end
      begin
        repeat (60) send_pixel(rand_pixel());
        end_burst();
      end
    join
    for (int ph = 0; ph < 6; ph++) begin
      set_direction(ph[0] ? rhpc_pkg::DIR_HSV_TO_RGB : rhpc_pkg::DIR_RGB_TO_HSV);
      repeat (100) send_pixel(rand_pixel());
      end_burst();
    end
    drain();
    if (sb.errors == 0)
      $display("PASS rgb_hsv_pixel_converter_unit");
    else
      $display("FAIL rgb_hsv_pixel_converter_unit");
    $finish;
  end
endmodule
